// ===== sv/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with string read.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Default sizes
  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;

  // Fixed field widths
  localparam int CAP_W  = 11;
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int BLEN_W = 7;

  // Input tdata: data_byte, burst_length, padded to whole bytes
  localparam int S_DATA_W = 16;
  // Output tdata: read_byte, bytes_returned, write_accepted, fill_level,
  // free_space, is_full, padded to whole bytes
  localparam int M_DATA_W = 40;

  // Operation selector carried on the input tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_BURST  = 2'd1,
    KIND_STRING = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  // Control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

// ===== sv/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/byte_ring_fifo_with_string_read.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_string_read
// Circular byte FIFO held in one RAM, with byte writes, burst reads, string
// reads that stop after a zero byte, and flush. Capacity is programmable.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer when            Carries
//  s_*      in         s_tvalid & s_tready      tuser: kind; tdata: byte, length
//  m_*      out        m_tvalid & m_tready      tuser: byte_valid; tlast: last
//  cfg_*    in         cfg_valid & cfg_ready    capacity (also flushes)
//
//  Write, flush and empty reads each load one result into the output register.
//  A read issues a RAM read when it is accepted, then returns one byte per cycle
//  from the RAM read port while the output is not stalled.
//  Synchronous reset empties the FIFO and sets capacity to DEPTH.
//  Back-pressure on m_* stalls the read run; the RAM output holds meanwhile.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_string_read
  import brf_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // bits: [7:0] data_byte, [14:8] burst_length, [15] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // bits: [1:0] kind
  input  logic [KIND_W-1:0]   s_tuser,
  input  logic                s_tvalid,
  output logic                s_tready,
  // bits: [7:0] read_byte, [14:8] bytes_returned, [15] write_accepted,
  //       [26:16] fill_level, [37:27] free_space, [38] is_full, [39] zero
  output logic [M_DATA_W-1:0] m_tdata,
  // bits: [0] byte_valid
  output logic                m_tuser,
  output logic                m_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                cfg_valid,
  output logic                cfg_ready
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [CAP_W-1:0]  DEPTH_CAP = (DEPTH > 2047) ? '1 : CAP_W'(DEPTH);
  localparam logic [BLEN_W-1:0] BURST_CAP = BLEN_W'(MAX_BURST);

  // Control state
  state_t            state, state_next;
  logic [CAP_W-1:0]  capacity;
  logic [AW-1:0]     rd_idx, wr_idx;
  logic [CAP_W-1:0]  count;
  logic              run_str;
  logic [BLEN_W-1:0] run_len, run_ret;

  // Output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_bvalid, out_last, out_acc, out_full;
  logic [BLEN_W-1:0] out_ret;
  logic [CAP_W-1:0]  out_fill, out_free;

  // Combinational control
  logic [CAP_W-1:0]  eff_cap;
  logic [AW:0]       rd_inc, wr_inc;
  logic [AW-1:0]     rd_adv, wr_adv;
  logic [BYTE_W-1:0] in_byte, ram_rdata;
  logic [BLEN_W-1:0] in_blen, blen_clip, run_n, emit_ret;
  kind_t             in_kind;
  logic              slot_free, in_fire, cfg_fire, emit_last;
  logic              ram_we, ram_re, do_flush, do_start, do_emit, load_out;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_bvalid, ld_last, ld_acc;
  logic [BLEN_W-1:0] ld_ret;
  logic [CAP_W-1:0]  ld_fill;

  // Effective capacity: zero acts as one, clamp to the memory depth
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (32'(capacity) > 32'(DEPTH_CAP)) begin
      eff_cap = DEPTH_CAP;
    end else begin
      eff_cap = capacity;
    end
  end

  // Index advance with wrap at the capacity
  assign rd_inc = {1'b0, rd_idx} + 1'b1;
  assign wr_inc = {1'b0, wr_idx} + 1'b1;
  assign rd_adv = (32'(rd_inc) >= 32'(eff_cap)) ? '0 : rd_inc[AW-1:0];
  assign wr_adv = (32'(wr_inc) >= 32'(eff_cap)) ? '0 : wr_inc[AW-1:0];

  // Unpack the input transfer and size the read run
  assign in_kind   = kind_t'(s_tuser);
  assign in_byte   = s_tdata[BYTE_W-1:0];
  assign in_blen   = s_tdata[BYTE_W+BLEN_W-1:BYTE_W];
  assign blen_clip = (in_blen > BURST_CAP) ? BURST_CAP : in_blen;
  assign run_n     = (count < CAP_W'(blen_clip)) ? count[BLEN_W-1:0] : blen_clip;

  // Handshakes
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Byte coming out of the RAM during a read run
  assign emit_ret  = run_ret + 1'b1;
  assign emit_last = (emit_ret == run_len) || (run_str && ram_rdata == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_start) state_next = ST_READ;
      end
      ST_READ: begin
        if (do_emit && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM strobes and output register load
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    do_flush  = 1'b0;
    do_start  = 1'b0;
    do_emit   = 1'b0;
    load_out  = 1'b0;
    ld_byte   = '0;
    ld_bvalid = 1'b0;
    ld_last   = 1'b1;
    ld_acc    = 1'b0;
    ld_ret    = '0;
    ld_fill   = count;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_WRITE: begin
              load_out = 1'b1;
              if (count < eff_cap) begin
                ram_we  = 1'b1;
                ld_acc  = 1'b1;
                ld_fill = count + 1'b1;
              end
            end
            KIND_FLUSH: begin
              do_flush = 1'b1;
              load_out = 1'b1;
              ld_fill  = '0;
            end
            default: begin
              // Burst or string read: an empty run gives one empty result
              if (run_n == '0) begin
                load_out = 1'b1;
              end else begin
                do_start = 1'b1;
                ram_re   = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) begin
          do_emit   = 1'b1;
          load_out  = 1'b1;
          ld_byte   = ram_rdata;
          ld_bvalid = 1'b1;
          ld_last   = emit_last;
          ld_ret    = emit_ret;
          ram_re    = !emit_last;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state and run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      run_str <= 1'b0;
      run_len <= '0;
      run_ret <= '0;
    end else begin
      state <= state_next;
      if (do_start) begin
        run_str <= (in_kind == KIND_STRING);
        run_len <= run_n;
        run_ret <= '0;
      end else if (do_emit) begin
        run_ret <= emit_ret;
      end
    end
  end

  // Capacity, indices and count; a capacity write also empties the FIFO
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= DEPTH_CAP;
      rd_idx   <= '0;
      wr_idx   <= '0;
      count    <= '0;
    end else if (cfg_fire) begin
      capacity <= cfg_data;
      rd_idx   <= '0;
      wr_idx   <= '0;
      count    <= '0;
    end else if (do_flush) begin
      rd_idx <= '0;
      wr_idx <= '0;
      count  <= '0;
    end else if (ram_we) begin
      wr_idx <= wr_adv;
      count  <= count + 1'b1;
    end else if (ram_re) begin
      rd_idx <= rd_adv;
      count  <= count - 1'b1;
    end
  end

  // Output register: advance on transfer, load when a result is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte   <= ld_byte;
      out_bvalid <= ld_bvalid;
      out_last   <= ld_last;
      out_acc    <= ld_acc;
      out_ret    <= ld_ret;
      out_fill   <= ld_fill;
      out_free   <= eff_cap - ld_fill;
      out_full   <= (ld_fill == eff_cap);
    end
  end

  // Byte store
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Pack the result
  assign m_tvalid = out_valid;
  assign m_tuser  = out_bvalid;
  assign m_tlast  = out_last;
  assign m_tdata  = {1'b0, out_full, out_free, out_fill, out_acc, out_ret, out_byte};

endmodule

// ===== tb/sv/byte_ring_fifo_with_string_read_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_string_read_tb
// Self-checking bench for the byte ring FIFO. A directed opening covers empty
// reads, zero-length and over-long reads, string stops, drops when full,
// wrap-around and flush. Random phases follow, each at its own capacity.
// A scoreboard class tracks the FIFO contents and checks every output
// transfer, field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_string_read_tb
  import brf_pkg::*;
;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_WAIT     = 18;
  localparam int RANDOM_ITEMS = 410;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int CAP_STEPS    = 9;
  localparam int PHASE_AW     = $clog2(CAP_STEPS);
  localparam int MEM_AW       = $clog2(DEPTH_DEF);
  localparam logic [CAP_W-1:0] PHASE_CAPS [CAP_STEPS] = '{
    11'd0, 11'd1, 11'd2, 11'd7, 11'd2047, 11'd64, 11'd1024, 11'd19, 11'd1023
  };

  // One output transfer as the FIFO should present it
  typedef struct {
    logic [BYTE_W-1:0] rbyte;
    logic              valid;
    logic              last;
    logic [BLEN_W-1:0] count;
    logic              accepted;
    logic [CAP_W-1:0]  fill;
    logic [CAP_W-1:0]  free;
    logic              full;
  } fifo_output_t;

  // Mirror of the FIFO contents plus the queue of outputs still owed
  class ring_fifo_scoreboard;
    logic [BYTE_W-1:0] byte_mem [DEPTH_DEF];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       held;
    int unsigned       cap_reg;
    fifo_output_t      expected_outputs [$];
    int unsigned       errors;

    function new();
      cap_reg = DEPTH_DEF;
      clear();
      errors = 0;
    endfunction

    function void clear();
      rd_ptr = 0;
      wr_ptr = 0;
      held = 0;
    endfunction

    // Register value as the FIFO applies it
    function int unsigned slots();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
      return cap_reg;
    endfunction

    function int unsigned next_slot(int unsigned idx);
      return (idx + 1 >= slots()) ? 0 : idx + 1;
    endfunction

    function int unsigned pending();
      return expected_outputs.size();
    endfunction

    // A capacity write also empties the FIFO
    function void load_capacity(logic [CAP_W-1:0] value);
      cap_reg = value;
      clear();
    endfunction

    function void push_output(logic [BYTE_W-1:0] b, logic v, logic l,
                              int unsigned run, logic acc);
      fifo_output_t o;
      o.rbyte    = b;
      o.valid    = v;
      o.last     = l;
      o.count    = BLEN_W'(run);
      o.accepted = acc;
      o.fill     = CAP_W'(held);
      o.free     = CAP_W'(slots() - held);
      o.full     = (held == slots());
      expected_outputs.push_back(o);
    endfunction

    // Work out the outputs that one accepted request causes
    function void predict_request(kind_t kind, logic [BYTE_W-1:0] data,
                                  logic [BLEN_W-1:0] len);
      int unsigned want;
      int unsigned n;
      logic [BYTE_W-1:0] b;
      logic stop;
      case (kind)
        KIND_WRITE: begin
          if (held < slots()) begin
            byte_mem[MEM_AW'(wr_ptr)] = data;
            wr_ptr = next_slot(wr_ptr);
            held++;
            push_output('0, 1'b0, 1'b1, 0, 1'b1);
          end else begin
            push_output('0, 1'b0, 1'b1, 0, 1'b0);
          end
        end
        KIND_FLUSH: begin
          clear();
          push_output('0, 1'b0, 1'b1, 0, 1'b0);
        end
        default: begin
          want = (len > MAX_BURST_DEF) ? MAX_BURST_DEF : len;
          n = (held < want) ? held : want;
          if (n == 0) begin
            push_output('0, 1'b0, 1'b1, 0, 1'b0);
          end else begin
            for (int unsigned k = 0; k < n; k++) begin
              b = byte_mem[MEM_AW'(rd_ptr)];
              rd_ptr = next_slot(rd_ptr);
              held--;
              stop = (k + 1 == n) || (kind == KIND_STRING && b == 8'h00);
              push_output(b, 1'b1, stop, k + 1, 1'b0);
              if (stop) break;
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [CAP_W-1:0] want,
                              logic [CAP_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one output transfer against the oldest outstanding output
    function void compare_output(logic [M_DATA_W-1:0] d, logic user,
                                 logic last);
      fifo_output_t want;
      if (expected_outputs.size() == 0) begin
        $display("%0t: output expected none got tdata %h tuser %b tlast %b",
                 $time, d, user, last);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      check_field("read_byte", CAP_W'(want.rbyte), CAP_W'(d[7:0]));
      check_field("byte_valid", CAP_W'(want.valid), CAP_W'(user));
      check_field("last_of_run", CAP_W'(want.last), CAP_W'(last));
      check_field("bytes_returned", CAP_W'(want.count), CAP_W'(d[14:8]));
      check_field("write_accepted", CAP_W'(want.accepted), CAP_W'(d[15]));
      check_field("fill_level", want.fill, d[26:16]);
      check_field("free_space", want.free, d[37:27]);
      check_field("is_full", CAP_W'(want.full), CAP_W'(d[38]));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic [S_DATA_W-1:0] s_tdata;
  logic [KIND_W-1:0]   s_tuser;
  logic                s_tvalid;
  logic                s_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [CAP_W-1:0]    cfg_data;
  logic                cfg_valid;
  logic                cfg_ready;

  ring_fifo_scoreboard fifo_model = new();
  int unsigned         src_max = MAX_WAIT;
  int unsigned         sink_max = MAX_WAIT;
  int unsigned         cycles = 0;

  byte_ring_fifo_with_string_read i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("byte_ring_fifo_with_string_read_tb NOT OK");
      $finish;
    end
  end

  // Note requests before checking outputs taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready === 1'b1)
        fifo_model.predict_request(kind_t'(s_tuser), s_tdata[7:0], s_tdata[14:8]);
      if (m_tvalid === 1'b1 && m_tready)
        fifo_model.compare_output(m_tdata, m_tuser, m_tlast);
    end
  end

  // Output side: hold off a random number of cycles before each transfer
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    forever begin
      stall = $urandom_range(0, sink_max);
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Present one request after a random gap and hold it until the transfer
  task automatic send_request(input kind_t kind, input logic [BYTE_W-1:0] data,
                              input logic [BLEN_W-1:0] len);
    int unsigned gap;
    gap = $urandom_range(0, src_max);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, len, data};
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  // Drop valid and wait until every owed output has been taken
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (fifo_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    fifo_model.load_capacity(value);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Mix of writes (zero bytes frequent, for string stops), reads and flushes
  task automatic random_request();
    int unsigned pick;
    logic [BLEN_W-1:0] len;
    logic [BYTE_W-1:0] data;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) < 7) ? BLEN_W'($urandom_range(0, 12))
                                     : BLEN_W'($urandom_range(0, 127));
    data = ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
    if (pick < 46)
      send_request(KIND_WRITE, data, len);
    else if (pick < 68)
      send_request(KIND_BURST, data, len);
    else if (pick < 96)
      send_request(KIND_STRING, data, len);
    else
      send_request(KIND_FLUSH, data, len);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned run;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_WRITE;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Empty FIFO: reads and flush give a single empty output
    send_request(KIND_BURST, 8'h00, 7'd5);
    send_request(KIND_STRING, 8'h00, 7'd3);
    send_request(KIND_FLUSH, 8'h00, 7'd0);
    // Fill with a zero-laced pattern
    send_request(KIND_WRITE, 8'h00, 7'd0);
    send_request(KIND_WRITE, 8'hFF, 7'd0);
    send_request(KIND_WRITE, 8'hA5, 7'd0);
    send_request(KIND_WRITE, 8'h5A, 7'd0);
    send_request(KIND_WRITE, 8'h00, 7'd0);
    send_request(KIND_WRITE, 8'h41, 7'd127);
    // Zero length, string stop on first byte, partial burst, over-long lengths
    send_request(KIND_BURST, 8'h00, 7'd0);
    send_request(KIND_STRING, 8'h00, 7'd64);
    send_request(KIND_BURST, 8'h00, 7'd2);
    send_request(KIND_STRING, 8'h00, 7'd127);
    send_request(KIND_BURST, 8'h00, 7'd127);
    // Flush with bytes held
    send_request(KIND_WRITE, 8'h80, 7'd0);
    send_request(KIND_WRITE, 8'h01, 7'd0);
    send_request(KIND_FLUSH, 8'hFF, 7'd127);
    send_request(KIND_BURST, 8'h00, 7'd4);
    // Small capacity: drop when full, then wrap both pointers
    settle();
    write_capacity(11'd3);
    send_request(KIND_WRITE, 8'h11, 7'd0);
    send_request(KIND_WRITE, 8'h22, 7'd0);
    send_request(KIND_WRITE, 8'h33, 7'd0);
    send_request(KIND_WRITE, 8'h44, 7'd0);
    send_request(KIND_BURST, 8'h00, 7'd2);
    send_request(KIND_WRITE, 8'h55, 7'd0);
    send_request(KIND_WRITE, 8'h66, 7'd0);
    send_request(KIND_STRING, 8'h00, 7'd64);

    // Random phases, each with its own capacity and idling pattern
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      write_capacity((phase < CAP_STEPS) ? PHASE_CAPS[PHASE_AW'(phase)]
                                         : CAP_W'($urandom_range(1, 100)));
      src_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      sink_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      run = $urandom_range(30, 50);
      repeat (run) begin
        random_request();
        sent++;
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fifo_model.errors == 0)
      $display("byte_ring_fifo_with_string_read_tb OK");
    else
      $display("byte_ring_fifo_with_string_read_tb NOT OK");
    $finish;
  end

endmodule
